FILE: rtl/wshl_pkg.sv
`default_nettype none
package wshl_pkg;

   localparam int CAPACITY    = 4096;
   localparam int MAX_LEN     = 45;
   localparam int HALF_BKT    = 26;
   localparam int NUM_BUCKETS = 26 * 2;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = IDX_W + 1;
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int BUF_AW      = $clog2(MAX_LEN);
   localparam int BKT_W       = $clog2(NUM_BUCKETS);
   localparam int MOD_W       = $clog2(HALF_BKT);
   localparam int CHR_AW      = $clog2(CAPACITY * MAX_LEN);

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BKT_W-1:0]  bkt_type;
   typedef logic [MOD_W-1:0]  mod_type;
   typedef logic [CHR_AW-1:0] chr_addr_type;

   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_LO_A = 8'h61;
   localparam logic [7:0] CHAR_LO_Z = 8'h7a;

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_LOOKUP = 1'b1;

   localparam logic [1:0] ERR_OK   = 2'd0;
   localparam logic [1:0] ERR_FULL = 2'd1;
   localparam logic [1:0] ERR_LONG = 2'd2;

   // entry write: length and chain link of one stored word
   typedef struct packed {
      logic    we;
      idx_type addr;
      cnt_type next;
      len_type len;
   } ent_wr_type;

   // character write into the entry text store
   typedef struct packed {
      logic         we;
      chr_addr_type addr;
      logic [7:0]   data;
   } chr_wr_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   // (running sum mod 26 + byte) mod 26, binary conditional subtract
   function automatic mod_type mod_add(input mod_type s, input logic [7:0] b);
      logic [8:0] x;
      x = {4'd0, s} + {1'b0, b};
      if (x >= 9'(HALF_BKT * 8)) x = x - 9'(HALF_BKT * 8);
      if (x >= 9'(HALF_BKT * 4)) x = x - 9'(HALF_BKT * 4);
      if (x >= 9'(HALF_BKT * 2)) x = x - 9'(HALF_BKT * 2);
      if (x >= 9'(HALF_BKT))     x = x - 9'(HALF_BKT);
      return x[MOD_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/wshl_store.sv
`default_nettype none
module wshl_store (
   input  wire                     clock,
   input  wshl_pkg::ent_wr_type    ent_wr,
   input  wshl_pkg::idx_type       ent_raddr,
   output wshl_pkg::cnt_type       ent_rnext,
   output wshl_pkg::len_type       ent_rlen,
   input  wshl_pkg::chr_wr_type    chr_wr,
   input  wshl_pkg::chr_addr_type  chr_raddr,
   output logic [7:0]              chr_rdata
);

   wshl_pkg::cnt_type next_mem [wshl_pkg::CAPACITY];
   wshl_pkg::len_type len_mem  [wshl_pkg::CAPACITY];
   logic [7:0]        chr_mem  [wshl_pkg::CAPACITY * wshl_pkg::MAX_LEN];

   // per-entry link and length
   always_ff @(posedge clock) begin
      if (ent_wr.we) begin
         next_mem[ent_wr.addr] <= ent_wr.next;
         len_mem[ent_wr.addr]  <= ent_wr.len;
      end
      ent_rnext <= next_mem[ent_raddr];
      ent_rlen  <= len_mem[ent_raddr];
   end

   // word text, MAX_LEN bytes per entry
   always_ff @(posedge clock) begin
      if (chr_wr.we) begin
         chr_mem[chr_wr.addr] <= chr_wr.data;
      end
      chr_rdata <= chr_mem[chr_raddr];
   end

endmodule
`default_nettype wire

FILE: rtl/word_set_hash_lookup_top.sv
`default_nettype none
// throughput: one request per cycle while a word streams in; after the last byte the next
//   request waits until the response is loaded into the output register
// reset: synchronous; chain heads marked empty through valid flops, word count cleared,
//   entry stores are not cleared and hold data only once written
module word_set_hash_lookup_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire        req_op,
   input  wire [7:0]  req_ch,
   input  wire        req_last,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_found,
   output logic [12:0] rsp_word_count,
   output logic [1:0] rsp_error
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HREAD  = 3'd1;
   localparam logic [2:0] ST_HWAIT  = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_LWAIT  = 3'd4;
   localparam logic [2:0] ST_CREAD  = 3'd5;
   localparam logic [2:0] ST_CCMP   = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   logic [2:0]        state_ff, state_in;
   wshl_pkg::len_type len_ff, len_in;
   wshl_pkg::mod_type sum_ff, sum_in;
   logic              seca_ff, seca_in;
   logic              long_ff, long_in;
   logic              op_ff, op_in;
   wshl_pkg::bkt_type bkt_ff, bkt_in;
   wshl_pkg::cnt_type cur_ff, cur_in;
   wshl_pkg::cnt_type nxt_ff, nxt_in;
   wshl_pkg::len_type pos_ff, pos_in;
   logic              found_ff, found_in;
   logic [1:0]        err_ff, err_in;
   wshl_pkg::cnt_type count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   wshl_pkg::cnt_type rsp_count_ff;
   logic [1:0]        rsp_err_ff;
   logic [wshl_pkg::NUM_BUCKETS-1:0] hvld_ff, hvld_in;

   wshl_pkg::cnt_type head_mem [wshl_pkg::NUM_BUCKETS];
   wshl_pkg::cnt_type head_q;
   logic              head_we;
   logic [7:0]        buf_mem [wshl_pkg::MAX_LEN];
   logic [7:0]        buf_q;
   logic              buf_we;

   logic                  accept;
   logic                  rsp_load;
   logic [7:0]            up_ch;
   wshl_pkg::cnt_type     head_cur;
   wshl_pkg::ent_wr_type  ent_wr;
   wshl_pkg::chr_wr_type  chr_wr;
   wshl_pkg::cnt_type     ent_rnext;
   wshl_pkg::len_type     ent_rlen;
   logic [7:0]            chr_rdata;
   wshl_pkg::chr_addr_type chr_raddr;

   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid & ~req_stall;
   assign up_ch          = wshl_pkg::upcase(req_ch);
   assign rsp_load       = (state_ff == ST_RESULT) & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_word_count = rsp_count_ff;
   assign rsp_error      = rsp_err_ff;
   assign head_cur       = hvld_ff[bkt_ff] ? head_q : wshl_pkg::cnt_type'(wshl_pkg::CAPACITY);
   assign chr_raddr      = wshl_pkg::chr_addr_type'(cur_ff[wshl_pkg::IDX_W-1:0])
                         * wshl_pkg::chr_addr_type'(wshl_pkg::MAX_LEN)
                         + wshl_pkg::chr_addr_type'(pos_ff);

   // byte capture into word buffer and into the next free entry slot
   assign buf_we      = accept & (len_ff < wshl_pkg::len_type'(wshl_pkg::MAX_LEN));
   assign chr_wr.we   = buf_we & (count_ff < wshl_pkg::cnt_type'(wshl_pkg::CAPACITY));
   assign chr_wr.addr = wshl_pkg::chr_addr_type'(count_ff[wshl_pkg::IDX_W-1:0])
                      * wshl_pkg::chr_addr_type'(wshl_pkg::MAX_LEN)
                      + wshl_pkg::chr_addr_type'(len_ff);
   assign chr_wr.data = req_ch;

   // insert commit
   assign head_we     = (state_ff == ST_HWAIT) & (op_ff == wshl_pkg::OP_INSERT);
   assign ent_wr.we   = head_we;
   assign ent_wr.addr = count_ff[wshl_pkg::IDX_W-1:0];
   assign ent_wr.next = head_cur;
   assign ent_wr.len  = len_ff;

   // chain heads and word buffer
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[bkt_ff] <= count_ff;
      end
      head_q <= head_mem[bkt_ff];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[len_ff[wshl_pkg::BUF_AW-1:0]] <= req_ch;
      end
      buf_q <= buf_mem[pos_ff[wshl_pkg::BUF_AW-1:0]];
   end

   wshl_store u_store (
      .clock     (clock),
      .ent_wr    (ent_wr),
      .ent_raddr (cur_ff[wshl_pkg::IDX_W-1:0]),
      .ent_rnext (ent_rnext),
      .ent_rlen  (ent_rlen),
      .chr_wr    (chr_wr),
      .chr_raddr (chr_raddr),
      .chr_rdata (chr_rdata)
   );

   // sequencer
   always_comb begin
      logic             long_n;
      wshl_pkg::mod_type sum_n;
      logic             seca_n;
      state_in = state_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      seca_in  = seca_ff;
      long_in  = long_ff;
      op_in    = op_ff;
      bkt_in   = bkt_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      err_in   = err_ff;
      count_in = count_ff;
      hvld_in  = hvld_ff;
      long_n   = long_ff;
      sum_n    = sum_ff;
      seca_n   = seca_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (buf_we) begin
                  sum_n  = wshl_pkg::mod_add(sum_ff, up_ch);
                  seca_n = seca_ff | ((len_ff == wshl_pkg::len_type'(1)) &
                                      (up_ch == wshl_pkg::CHAR_UP_A));
                  len_in = len_ff + wshl_pkg::len_type'(1);
               end else begin
                  long_n = 1'b1;
               end
               sum_in  = sum_n;
               seca_in = seca_n;
               long_in = long_n;
               if (req_last) begin
                  op_in    = req_op;
                  bkt_in   = wshl_pkg::bkt_type'(sum_n)
                           + (seca_n ? wshl_pkg::bkt_type'(wshl_pkg::HALF_BKT) : '0);
                  found_in = 1'b0;
                  if (long_n) begin
                     err_in   = wshl_pkg::ERR_LONG;
                     state_in = ST_RESULT;
                  end else if (req_op == wshl_pkg::OP_INSERT &&
                               count_ff == wshl_pkg::cnt_type'(wshl_pkg::CAPACITY)) begin
                     err_in   = wshl_pkg::ERR_FULL;
                     state_in = ST_RESULT;
                  end else begin
                     err_in   = wshl_pkg::ERR_OK;
                     state_in = ST_HREAD;
                  end
               end
            end
         end
         ST_HREAD: state_in = ST_HWAIT;
         ST_HWAIT: begin
            if (op_ff == wshl_pkg::OP_INSERT) begin
               hvld_in[bkt_ff] = 1'b1;
               count_in        = count_ff + wshl_pkg::cnt_type'(1);
               state_in        = ST_RESULT;
            end else begin
               cur_in   = head_cur;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (cur_ff >= count_ff) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_LWAIT;
            end
         end
         ST_LWAIT: begin
            if (ent_rlen != len_ff) begin
               cur_in   = ent_rnext;
               state_in = ST_WALK;
            end else begin
               nxt_in   = ent_rnext;
               pos_in   = '0;
               state_in = ST_CREAD;
            end
         end
         ST_CREAD: state_in = ST_CCMP;
         ST_CCMP: begin
            if (wshl_pkg::upcase(chr_rdata) != wshl_pkg::upcase(buf_q)) begin
               cur_in   = nxt_ff;
               state_in = ST_WALK;
            end else if (pos_ff == len_ff - wshl_pkg::len_type'(1)) begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end else begin
               pos_in   = pos_ff + wshl_pkg::len_type'(1);
               state_in = ST_CREAD;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               len_in   = '0;
               sum_in   = '0;
               seca_in  = 1'b0;
               long_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         sum_ff       <= '0;
         seca_ff      <= 1'b0;
         long_ff      <= 1'b0;
         count_ff     <= '0;
         hvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         seca_ff      <= seca_in;
         long_ff      <= long_in;
         count_ff     <= count_in;
         hvld_ff      <= hvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      bkt_ff   <= bkt_in;
      cur_ff   <= cur_in;
      nxt_ff   <= nxt_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      err_ff   <= err_in;
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_count_ff <= count_ff;
         rsp_err_ff   <= err_ff;
      end
   end

endmodule
`default_nettype wire

FILE: dv/tb_word_set_hash_lookup_top.sv
`default_nettype none
module tb_word_set_hash_lookup_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = wshl_pkg::OP_INSERT;
   logic [7:0]  req_ch = 8'h41;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [12:0] rsp_word_count;
   logic [1:0]  rsp_error;

   typedef struct packed {
      logic        found;
      logic [12:0] word_count;
      logic [1:0]  error;
   } word_result_type;

   word_result_type result_queue[$];
   int           fail_count = 0;
   longint       cycle_count = 0;
   int           burst_left = 0;
   bit           allow_stall = 1'b1;

   // shadow of the word set
   byte unsigned dict_word[$][$];
   int           dict_next[$];
   int           dict_head[wshl_pkg::NUM_BUCKETS];
   byte unsigned word_bytes[$];
   int           word_sum;
   bit           word_second_a;
   bit           word_overflow;

   word_set_hash_lookup_top u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("tb_word_set_hash_lookup_top: done, errors");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (!allow_stall) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((cycle_count / 200) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      word_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_queue.size() == 0) begin
            $error("unexpected response");
            fail_count++;
         end else begin
            exp_r = result_queue.pop_front();
            if (rsp_found !== exp_r.found) begin
               $error("found: expected %0d actual %0d", exp_r.found, rsp_found);
               fail_count++;
            end
            if (rsp_word_count !== exp_r.word_count) begin
               $error("word_count: expected %0d actual %0d", exp_r.word_count,
                      rsp_word_count);
               fail_count++;
            end
            if (rsp_error !== exp_r.error) begin
               $error("error: expected %0d actual %0d", exp_r.error, rsp_error);
               fail_count++;
            end
         end
      end
   end

   function automatic byte unsigned fold_case(byte unsigned c);
      if (c >= 8'h61 && c <= 8'h7a) return c - 8'h20;
      return c;
   endfunction

   // predict the response for one request byte
   function automatic void predict_byte(logic op, byte unsigned c, logic last);
      word_result_type r;
      int bkt, cur, steps;
      bit same;
      if (word_bytes.size() < wshl_pkg::MAX_LEN) begin
         if (word_bytes.size() == 1 && fold_case(c) == wshl_pkg::CHAR_UP_A)
            word_second_a = 1'b1;
         word_sum += fold_case(c);
         word_bytes.push_back(c);
      end else begin
         word_overflow = 1'b1;
      end
      if (!last) return;
      bkt = (word_sum % wshl_pkg::HALF_BKT) + (word_second_a ? wshl_pkg::HALF_BKT : 0);
      r.found = 1'b0;
      r.error = wshl_pkg::ERR_OK;
      if (word_overflow) begin
         r.error = wshl_pkg::ERR_LONG;
      end else if (op == wshl_pkg::OP_INSERT) begin
         if (dict_word.size() >= wshl_pkg::CAPACITY) begin
            r.error = wshl_pkg::ERR_FULL;
         end else begin
            dict_word.push_back(word_bytes);
            dict_next.push_back(dict_head[bkt]);
            dict_head[bkt] = dict_word.size() - 1;
         end
      end else begin
         cur = dict_head[bkt];
         steps = 0;
         while (cur < dict_word.size() && steps < dict_word.size() && !r.found) begin
            same = (dict_word[cur].size() == word_bytes.size());
            for (int i = 0; same && i < word_bytes.size(); i++)
               if (fold_case(dict_word[cur][i]) != fold_case(word_bytes[i])) same = 1'b0;
            if (same) r.found = 1'b1;
            cur = dict_next[cur];
            steps++;
         end
      end
      r.word_count = 13'(dict_word.size());
      result_queue.push_back(r);
      word_bytes.delete();
      word_sum = 0;
      word_second_a = 1'b0;
      word_overflow = 1'b0;
   endfunction

   // send one request, with bursty gaps
   task automatic send_byte(logic op, byte unsigned c, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_ch <= c;
      req_last <= last;
      predict_byte(op, c, last);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_word(logic op, byte unsigned w[$]);
      for (int i = 0; i < w.size(); i++)
         send_byte((i == w.size() - 1) ? op : logic'($urandom_range(0, 1)), w[i],
                   i == w.size() - 1);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (result_queue.size() != 0);
   endtask

   function automatic void make_word(output byte unsigned w[$], input int len,
                                     input bit letters);
      w.delete();
      for (int i = 0; i < len; i++)
         w.push_back(letters ? byte'($urandom_range(0, 1) ? $urandom_range(8'h41, 8'h44)
                                                           : $urandom_range(8'h61, 8'h64))
                             : byte'($urandom_range(1, 255)));
   endfunction

   // extremes, case folding, second-byte A, over-long words
   task automatic test_directed;
      byte unsigned w[$];
      w = '{8'h61};              send_word(wshl_pkg::OP_LOOKUP, w);
      send_word(wshl_pkg::OP_INSERT, w);
      w = '{8'h41};              send_word(wshl_pkg::OP_LOOKUP, w);
      w = '{8'h62, 8'h61};       send_word(wshl_pkg::OP_INSERT, w);
      w = '{8'h42, 8'h41};       send_word(wshl_pkg::OP_LOOKUP, w);
      w = '{8'h42, 8'h42};       send_word(wshl_pkg::OP_LOOKUP, w);
      w = '{8'hff, 8'h01, 8'h7b, 8'h60, 8'h40, 8'h5b};
      send_word(wshl_pkg::OP_INSERT, w);
      send_word(wshl_pkg::OP_LOOKUP, w);
      w = '{8'hff, 8'h01};       send_word(wshl_pkg::OP_LOOKUP, w);
      send_word(wshl_pkg::OP_INSERT, w);
      send_word(wshl_pkg::OP_LOOKUP, w);
      make_word(w, wshl_pkg::MAX_LEN, 1);
      send_word(wshl_pkg::OP_INSERT, w);
      send_word(wshl_pkg::OP_LOOKUP, w);
      make_word(w, wshl_pkg::MAX_LEN + 1, 1);
      send_word(wshl_pkg::OP_INSERT, w);
      send_word(wshl_pkg::OP_LOOKUP, w);
      make_word(w, wshl_pkg::MAX_LEN + 5, 0);
      send_word(wshl_pkg::OP_INSERT, w);
      drain();
   endtask

   // random words from a small alphabet so lookups hit often
   task automatic test_random(int n_words);
      byte unsigned w[$];
      int len = 1;
      for (int k = 0; k < n_words; k++) begin
         case ($urandom_range(0, 19))
            0: len = $urandom_range(wshl_pkg::MAX_LEN - 1, wshl_pkg::MAX_LEN + 3);
            1, 2: begin
               len = $urandom_range(1, 6);
               make_word(w, len, 0);
            end
            default: len = $urandom_range(1, 4);
         endcase
         if (w.size() == 0 || $urandom_range(0, 19) > 2) make_word(w, len, 1);
         send_word(logic'($urandom_range(0, 1)), w);
         w.delete();
      end
      drain();
   endtask

   // fill the store to capacity, then inserts report full and lookups still work
   task automatic test_store_full;
      byte unsigned w[$];
      allow_stall = 1'b0;
      while (dict_word.size() < wshl_pkg::CAPACITY) begin
         w = '{8'h5a};
         send_word(wshl_pkg::OP_INSERT, w);
      end
      allow_stall = 1'b1;
      drain();
      w = '{8'h7a};
      send_word(wshl_pkg::OP_INSERT, w);
      send_word(wshl_pkg::OP_LOOKUP, w);
      w = '{8'h61, 8'h61};
      send_word(wshl_pkg::OP_INSERT, w);
      send_word(wshl_pkg::OP_LOOKUP, w);
      make_word(w, wshl_pkg::MAX_LEN + 2, 1);
      send_word(wshl_pkg::OP_LOOKUP, w);
      drain();
   endtask

   initial begin
      for (int i = 0; i < wshl_pkg::NUM_BUCKETS; i++) dict_head[i] = wshl_pkg::CAPACITY;
      word_sum = 0;
      word_second_a = 1'b0;
      word_overflow = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200);
      test_random(150);
      test_store_full();
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && result_queue.size() == 0)
         $display("tb_word_set_hash_lookup_top: done, clean");
      else
         $display("tb_word_set_hash_lookup_top: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
